### rtl/sparse_cosine_similarity_defines.svh
// ----------------------------------------------------------------------------
// sparse cosine similarity assertion macros
// shorthand for clocked implication checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef SPARSE_COSINE_SIMILARITY_DEFINES_SVH
`define SPARSE_COSINE_SIMILARITY_DEFINES_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// widths, types and saturating add shared by the cosine similarity block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  localparam int USER_ID_BITS = 20;
  localparam int RATING_BITS  = 12;
  localparam int PROD_BITS    = 2 * RATING_BITS;
  localparam int ACC_BITS     = 48;
  localparam int HALF_BITS    = ACC_BITS / 2;
  localparam int NPROD_BITS   = 2 * ACC_BITS;
  localparam int ROOT_BITS    = ACC_BITS;
  localparam int FRAC_BITS    = 14;
  localparam int SIM_BITS     = 16;
  localparam int MAG_BITS     = FRAC_BITS + 1;
  localparam int NUM_BITS     = ACC_BITS + FRAC_BITS;

  localparam int SQRT_STEPS    = NPROD_BITS / 2;
  localparam int SQRT_CNT_BITS = $clog2(SQRT_STEPS);
  localparam int SQRT_REM_BITS = ROOT_BITS + 3;
  localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [MAG_BITS-1:0] SIM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic take;
    logic apply;
    logic clear;
  } acc_ctl_t;

  function automatic acc_t sat_add(acc_t acc, prod_t p);
    logic signed [ACC_BITS:0] sum;
    sum = {acc[ACC_BITS-1], acc} + {{(ACC_BITS+1-PROD_BITS){p[PROD_BITS-1]}}, p};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      sat_add = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = sum[ACC_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/scs_mul.sv
// ----------------------------------------------------------------------------
// scs_mul
// unsigned norm product built from four half-width partial products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_mul
  import scs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [ACC_BITS-1:0]   a,
  input  wire logic [ACC_BITS-1:0]   b,
  output logic                       done,
  output logic [NPROD_BITS-1:0]      prod
);

  logic                  run;
  logic                  pvalid;
  logic                  plast;
  logic [1:0]            cnt;
  logic [1:0]            pw;
  logic [ACC_BITS-1:0]   opa;
  logic [ACC_BITS-1:0]   opb;
  logic [ACC_BITS-1:0]   pp;
  logic [HALF_BITS-1:0]  a_sel;
  logic [HALF_BITS-1:0]  b_sel;
  logic [NPROD_BITS-1:0] pp_ext;
  logic [NPROD_BITS-1:0] pp_shift;

  assign a_sel  = cnt[1] ? opa[ACC_BITS-1:HALF_BITS] : opa[HALF_BITS-1:0];
  assign b_sel  = cnt[0] ? opb[ACC_BITS-1:HALF_BITS] : opb[HALF_BITS-1:0];
  assign pp_ext = {{ACC_BITS{1'b0}}, pp};

  always_comb begin
    unique case (pw)
      2'd0:    pp_shift = pp_ext;
      2'd1:    pp_shift = pp_ext << HALF_BITS;
      2'd2:    pp_shift = pp_ext << ACC_BITS;
      default: pp_shift = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      pvalid <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done   <= pvalid && plast;
      pvalid <= run;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa  <= a;
      opb  <= b;
      prod <= '0;
    end else begin
      if (run) begin
        pp    <= a_sel * b_sel;
        pw    <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        plast <= (cnt == 2'd3);
      end
      if (pvalid) begin
        prod <= prod + pp_shift;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/scs_sqrt.sv
// ----------------------------------------------------------------------------
// scs_sqrt
// floor square root, two radicand bits per cycle, shared trial subtractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_sqrt
  import scs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [NPROD_BITS-1:0] rad,
  output logic                       done,
  output logic [ROOT_BITS-1:0]       root
);

  localparam logic [SQRT_CNT_BITS-1:0] LAST_STEP = SQRT_CNT_BITS'(SQRT_STEPS - 1);

  logic                     run;
  logic [SQRT_CNT_BITS-1:0] cnt;
  logic [NPROD_BITS-1:0]    rad_q;
  logic [SQRT_REM_BITS-1:0] rem;
  logic [SQRT_REM_BITS-1:0] rem_sh;
  logic [SQRT_REM_BITS-1:0] trial;
  logic                     ge;

  assign rem_sh = {rem[SQRT_REM_BITS-3:0], rad_q[NPROD_BITS-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_q <= rad;
      rem   <= '0;
      root  <= '0;
    end else if (run) begin
      rad_q <= rad_q << 2;
      rem   <= ge ? (rem_sh - trial) : rem_sh;
      root  <= {root[ROOT_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/scs_div.sv
// ----------------------------------------------------------------------------
// scs_div
// restoring divider for |dot| * 2^14 / root, round half up, clamp at one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_div
  import scs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [ACC_BITS-1:0]  mag,
  input  wire logic [ROOT_BITS-1:0] den,
  output logic                      done,
  output logic [MAG_BITS-1:0]       quo
);

  localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(NUM_BITS - 1);

  logic                    run;
  logic                    fin;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [NUM_BITS-1:0]     num;
  logic [ROOT_BITS-1:0]    den_q;
  logic [ROOT_BITS-1:0]    rem;
  logic [ROOT_BITS:0]      rem_sh;
  logic                    ge;
  logic [FRAC_BITS-1:0]    q;
  logic                    over;
  logic                    rnd;

  assign rem_sh = {rem, num[NUM_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rnd    = ({rem, 1'b0} >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= {mag, {FRAC_BITS{1'b0}}};
      den_q <= den;
      rem   <= '0;
      q     <= '0;
      over  <= 1'b0;
    end else if (run) begin
      num  <= num << 1;
      rem  <= ge ? ROOT_BITS'(rem_sh - {1'b0, den_q}) : rem_sh[ROOT_BITS-1:0];
      q    <= {q[FRAC_BITS-2:0], ge};
      over <= over | q[FRAC_BITS-1];
    end
    if (fin) begin
      quo <= over ? SIM_ONE : ({1'b0, q} + {{FRAC_BITS{1'b0}}, rnd});
    end
  end

endmodule

`default_nettype wire

### rtl/scs_accum.sv
// ----------------------------------------------------------------------------
// scs_accum
// merge join of the record stream and saturating dot and norm accumulators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_accum
  import scs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire acc_ctl_t                ctl,
  input  wire logic                    side,
  input  wire logic [USER_ID_BITS-1:0] user_id,
  input  wire logic signed [RATING_BITS-1:0] rating,
  output acc_t                         dot,
  output acc_t                         norm_first,
  output acc_t                         norm_second
);

  logic                           held_valid;
  logic                           held_side;
  logic [USER_ID_BITS-1:0]        held_user;
  logic signed [RATING_BITS-1:0]  held_rating;
  logic                           match;
  logic                           match_q;
  logic signed [RATING_BITS-1:0]  ra;
  logic signed [RATING_BITS-1:0]  rb;
  prod_t                          p_ab;
  prod_t                          p_aa;
  prod_t                          p_bb;

  assign match = held_valid && (held_side != side) && (held_user == user_id);
  assign ra    = held_side ? rating : held_rating;
  assign rb    = held_side ? held_rating : rating;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      match_q     <= 1'b0;
      dot         <= '0;
      norm_first  <= '0;
      norm_second <= '0;
    end else if (ctl.clear) begin
      held_valid  <= 1'b0;
      match_q     <= 1'b0;
      dot         <= '0;
      norm_first  <= '0;
      norm_second <= '0;
    end else begin
      if (ctl.take) begin
        held_valid <= !match;
        match_q    <= match;
      end
      if (ctl.apply && match_q) begin
        dot         <= sat_add(dot, p_ab);
        norm_first  <= sat_add(norm_first, p_aa);
        norm_second <= sat_add(norm_second, p_bb);
        match_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      p_ab <= ra * rb;
      p_aa <= ra * ra;
      p_bb <= rb * rb;
      if (!match) begin
        held_side   <= side;
        held_user   <= user_id;
        held_rating <= rating;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sparse_cosine_similarity.sv
// ----------------------------------------------------------------------------
// sparse_cosine_similarity
// Cosine similarity of two sparse rating columns by merge join. Records come
// as one stream sorted by user id; a record meeting a record of the other
// column for the same user adds its product and squares to saturating 48-bit
// accumulators. On the record flagged last, the block returns
// dot / sqrt(norm_first * norm_second) as signed Q1.14 (0 when a norm is
// zero) and clears for the next pair. Each record is accepted, then
// accumulated, and no further record is taken meanwhile. After a last
// record the norm product on a 24x24 multiplier, the two-bits-per-cycle
// root and the one-bit-per-cycle divider run in turn before its result
// is offered. The result waits in an output register while the next
// pair's records are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_cosine_similarity_defines.svh"

module sparse_cosine_similarity
  import scs_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rec_valid,
  output logic                               rec_stall,
  input  wire logic                          side,
  input  wire logic [USER_ID_BITS-1:0]       user_id,
  input  wire logic signed [RATING_BITS-1:0] rating,
  input  wire logic                          last,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic signed [SIM_BITS-1:0]         similarity
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_START,
    S_MUL,
    S_SQRT,
    S_DIV,
    S_DONE
  } state_t;

  state_t                state;
  logic                  last_q;
  logic                  zero_den;
  logic                  neg;
  acc_ctl_t              ctl;
  acc_t                  dot;
  acc_t                  norm_first;
  acc_t                  norm_second;
  logic [ACC_BITS-1:0]   mag;
  logic                  nz;
  logic                  load;
  logic                  mul_start;
  logic                  mul_done;
  logic [NPROD_BITS-1:0] prod;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [ROOT_BITS-1:0]  root;
  logic                  div_start;
  logic                  div_done;
  logic [MAG_BITS-1:0]   quo;
  logic [SIM_BITS-1:0]   sim_mag;

  assign rec_stall  = (state != S_IDLE);
  assign nz         = (norm_first != '0) && (norm_second != '0);
  assign neg        = dot[ACC_BITS-1];
  assign mag        = neg ? (~dot + 1'b1) : dot;
  assign load       = (state == S_DONE) && !(res_valid && res_stall);
  assign mul_start  = (state == S_START) && nz;
  assign sqrt_start = (state == S_MUL) && mul_done;
  assign div_start  = (state == S_SQRT) && sqrt_done;
  assign sim_mag    = zero_den ? '0 : {{(SIM_BITS-MAG_BITS){1'b0}}, quo};

  assign ctl.take   = rec_valid && !rec_stall;
  assign ctl.apply  = (state == S_ACC);
  assign ctl.clear  = load;

  scs_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .side        (side),
    .user_id     (user_id),
    .rating      (rating),
    .dot         (dot),
    .norm_first  (norm_first),
    .norm_second (norm_second)
  );

  scs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (norm_first),
    .b     (norm_second),
    .done  (mul_done),
    .prod  (prod)
  );

  scs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (prod),
    .done  (sqrt_done),
    .root  (root)
  );

  scs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .den   (root),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_q    <= 1'b0;
      zero_den  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctl.take) begin
            last_q <= last;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          state <= last_q ? S_START : S_IDLE;
        end
        S_START: begin
          zero_den <= !nz;
          state    <= nz ? S_MUL : S_DONE;
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            res_valid  <= 1'b1;
            similarity <= neg ? -$signed(sim_mag) : $signed(sim_mag);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SCS_ASSERT_NOW(a_sim_range, clk, rst, res_valid,
    (similarity <= 16'sd16384) && (similarity >= -16'sd16384), "similarity out of range")
  `SCS_ASSERT_NOW(a_norm_sign, clk, rst, 1'b1,
    !norm_first[ACC_BITS-1] && !norm_second[ACC_BITS-1], "norm accumulator negative")
  `SCS_ASSERT_NOW(a_div_den, clk, rst, div_start, root != '0, "divide by zero root")
  `SCS_ASSERT_NEXT(a_clear, clk, rst, ctl.clear,
    (dot == '0) && (norm_first == '0) && (norm_second == '0), "accumulators not cleared")
  `SCS_ASSERT_NEXT(a_load, clk, rst, load, res_valid, "result not offered")

endmodule

`default_nettype wire

### sim/sparse_cosine_similarity_test.sv
// ----------------------------------------------------------------------------
// sparse cosine similarity testbench
// Drives merged rating streams through the block with random idling on both
// sides, predicts each similarity with a bit-exact fixed point model of the
// merge join, root and divide, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_cosine_similarity_test;
  import scs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int Q14_ONE        = 16384;
  localparam logic signed [RATING_BITS-1:0] RATING_MIN = 12'h800;
  localparam logic signed [RATING_BITS-1:0] RATING_MAX = 12'h7FF;

  typedef struct {
    logic                          side;
    logic [USER_ID_BITS-1:0]       user;
    logic signed [RATING_BITS-1:0] rating;
    logic                          last;
  } record_t;

  class similarity_board;
    logic                          held_valid;
    logic                          held_side;
    logic [USER_ID_BITS-1:0]       held_user;
    logic signed [RATING_BITS-1:0] held_rating;
    acc_t                          dot_sum;
    acc_t                          norm_a;
    acc_t                          norm_b;
    logic signed [SIM_BITS-1:0]    expected_similarity[$];
    int                            failures;

    function new();
      clear();
      failures = 0;
    endfunction

    function void clear();
      held_valid  = 1'b0;
      held_side   = 1'b0;
      held_user   = '0;
      held_rating = '0;
      dot_sum     = '0;
      norm_a      = '0;
      norm_b      = '0;
    endfunction

    function acc_t sat_accumulate(acc_t acc, acc_t p);
      logic signed [ACC_BITS:0] total;
      total = {acc[ACC_BITS-1], acc} + {p[ACC_BITS-1], p};
      if (total[ACC_BITS] != total[ACC_BITS-1]) begin
        return total[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end
      return total[ACC_BITS-1:0];
    endfunction

    function logic signed [SIM_BITS-1:0] predict_similarity();
      logic [127:0]          norm_product;
      logic [127:0]          trial;
      logic [127:0]          root;
      logic [127:0]          numer;
      logic [127:0]          quot;
      logic [127:0]          remain;
      logic [ACC_BITS-1:0]   mag;
      int                    i;
      norm_product = 128'(unsigned'(norm_a)) * 128'(unsigned'(norm_b));
      if (norm_product == 0) begin
        return '0;
      end
      root = '0;
      for (i = 63; i >= 0; i--) begin
        trial = root | (128'd1 << i);
        if (trial * trial <= norm_product) begin
          root = trial;
        end
      end
      mag = dot_sum[ACC_BITS-1] ? ACC_BITS'(-dot_sum) : ACC_BITS'(dot_sum);
      numer = 128'(mag) << FRAC_BITS;
      quot = numer / root;
      remain = numer % root;
      // round half up, only while the quotient is still in range
      if (quot < (128'd1 << 20) && 2 * remain >= root) begin
        quot = quot + 1;
      end
      if (quot > 128'(Q14_ONE)) begin
        quot = 128'(Q14_ONE);
      end
      return dot_sum[ACC_BITS-1] ? -SIM_BITS'(quot) : SIM_BITS'(quot);
    endfunction

    function void note_record(logic s, logic [USER_ID_BITS-1:0] u,
                              logic signed [RATING_BITS-1:0] r, logic l);
      acc_t a;
      acc_t b;
      if (held_valid && held_side != s && held_user == u) begin
        if (held_side == 1'b0) begin
          a = held_rating;
          b = r;
        end else begin
          a = r;
          b = held_rating;
        end
        dot_sum = sat_accumulate(dot_sum, a * b);
        norm_a  = sat_accumulate(norm_a, a * a);
        norm_b  = sat_accumulate(norm_b, b * b);
        held_valid = 1'b0;
      end else begin
        held_valid  = 1'b1;
        held_side   = s;
        held_user   = u;
        held_rating = r;
      end
      if (l) begin
        expected_similarity.push_back(predict_similarity());
        clear();
      end
    endfunction

    function void check_similarity(logic signed [SIM_BITS-1:0] got);
      logic signed [SIM_BITS-1:0] want;
      if (expected_similarity.size() == 0) begin
        $error("similarity: no result expected, actual %0d", got);
        failures++;
        return;
      end
      want = expected_similarity.pop_front();
      if (got !== want) begin
        $error("similarity: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction

    function int pending();
      return expected_similarity.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          rec_valid;
  logic                          rec_stall;
  logic                          side;
  logic [USER_ID_BITS-1:0]       user_id;
  logic signed [RATING_BITS-1:0] rating;
  logic                          last;
  logic                          res_valid;
  logic                          res_stall;
  logic signed [SIM_BITS-1:0]    similarity;

  similarity_board board = new();
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  calm_phase = 1'b0;
  bit  hold_request = 1'b0;

  sparse_cosine_similarity dut (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .side      (side),
    .user_id   (user_id),
    .rating    (rating),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .similarity(similarity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitors and watchdog
  always @(posedge clk) begin
    if (!rst && rec_valid && !rec_stall) begin
      board.note_record(side, user_id, rating, last);
    end
    if (!rst && res_valid && !res_stall) begin
      board.check_similarity(similarity);
    end
    if ((rec_valid && !rec_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sparse_cosine_similarity test failed");
      $finish;
    end
  end

  // result side stalls
  initial begin
    res_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [RATING_BITS-1:0] random_rating();
    case ($urandom_range(0, 7))
      0:       return RATING_MIN;
      1:       return RATING_MAX;
      2:       return '0;
      default: return RATING_BITS'($urandom);
    endcase
  endfunction

  task automatic send_record(input logic s, input logic [USER_ID_BITS-1:0] u,
                             input logic signed [RATING_BITS-1:0] r, input logic l);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      rec_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    rec_valid <= 1'b1;
    side      <= s;
    user_id   <= u;
    rating    <= r;
    last      <= l;
    do @(posedge clk); while (rec_stall);
    items_sent++;
  endtask

  // one pair stream, mostly sorted with matched users, some noise
  task automatic random_pair(input int n_users);
    record_t                 recs[$];
    record_t                 rec;
    logic [USER_ID_BITS-1:0] u;
    logic                    first_side;
    int                      kind;
    int                      k;
    u = USER_ID_BITS'($urandom);
    for (k = 0; k < n_users; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        u = u + USER_ID_BITS'($urandom_range(1, 5000));
      end else begin
        u = u + USER_ID_BITS'($urandom_range(0, 2));
      end
      kind = $urandom_range(0, 9);
      first_side = 1'($urandom_range(0, 1));
      rec.user = u;
      rec.last = 1'b0;
      rec.side = first_side;
      rec.rating = random_rating();
      if (kind == 9) begin
        rec.user = USER_ID_BITS'($urandom);
      end
      recs.push_back(rec);
      if (kind == 8) begin
        rec.rating = random_rating();
        recs.push_back(rec);
      end
      if (kind <= 5 || kind == 8) begin
        rec.side = ~first_side;
        rec.rating = random_rating();
        recs.push_back(rec);
      end
    end
    recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) begin
      send_record(recs[i].side, recs[i].user, recs[i].rating, recs[i].last);
    end
  endtask

  function automatic int pair_users();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
  endfunction

  initial begin
    rst       <= 1'b1;
    rec_valid <= 1'b0;
    side      <= 1'b0;
    user_id   <= '0;
    rating    <= '0;
    last      <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // lone record, zero denominator
    send_record(1'b0, 20'h00000, RATING_MIN, 1'b1);
    // extremes, equal and opposite
    send_record(1'b0, 20'h00000, RATING_MIN, 1'b0);
    send_record(1'b1, 20'h00000, RATING_MIN, 1'b1);
    send_record(1'b1, 20'hFFFFF, RATING_MIN, 1'b0);
    send_record(1'b0, 20'hFFFFF, RATING_MAX, 1'b1);
    // same column drop, other user drop, unmatched last
    send_record(1'b0, 20'd5, 12'sd100, 1'b0);
    send_record(1'b0, 20'd5, 12'sd200, 1'b0);
    send_record(1'b1, 20'd5, 12'sd300, 1'b0);
    send_record(1'b1, 20'd6, 12'sd7, 1'b0);
    send_record(1'b0, 20'd7, -12'sd9, 1'b1);
    // orthogonal columns
    send_record(1'b0, 20'd1, 12'sd256, 1'b0);
    send_record(1'b1, 20'd1, 12'sd256, 1'b0);
    send_record(1'b0, 20'd2, 12'sd256, 1'b0);
    send_record(1'b1, 20'd2, -12'sd256, 1'b1);
    // one norm zero
    send_record(1'b0, 20'd3, 12'sd0, 1'b0);
    send_record(1'b1, 20'd3, 12'sd5, 1'b1);
    // unsorted stream
    send_record(1'b0, 20'd20, 12'sd50, 1'b0);
    send_record(1'b1, 20'd3, 12'sd60, 1'b0);
    send_record(1'b0, 20'd3, 12'sd70, 1'b1);
    // two matched users, ratings of like sign per user
    send_record(1'b1, 20'd9, 12'sd3, 1'b0);
    send_record(1'b0, 20'd9, 12'sd5, 1'b0);
    send_record(1'b0, 20'd10, -12'sd1, 1'b0);
    send_record(1'b1, 20'd10, -12'sd1, 1'b1);

    while (items_sent < 500) random_pair(pair_users());

    // long result hold while records keep coming
    hold_request = 1'b1;
    repeat (6) random_pair($urandom_range(1, 3));

    // sender pause until all results are in
    rec_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);

    while (items_sent < 1050) random_pair(pair_users());
    calm_phase = 1'b1;
    while (items_sent < 1200) random_pair(pair_users());

    rec_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("sparse_cosine_similarity test passed");
    end else begin
      $display("sparse_cosine_similarity test failed");
    end
    $finish;
  end

endmodule
